/* hw/rtl/sida_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream ID allocator package
// Operation and status codes and the invalid queue marker shared by the
// allocator and its binding tables.
// ----------------------------------------------------------------------------
package sida_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_BIND_SQ = 2'd2,
    OP_BIND_CQ = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_DEVICE = 3'd1,
    ST_BAD_STREAM = 3'd2,
    ST_BAD_QUEUE  = 3'd3,
    ST_NONE_FREE  = 3'd4,
    ST_LIST_FULL  = 3'd5
  } status_t;

  localparam logic [7:0] NO_QUEUE = 8'hFF;

endpackage
`default_nettype wire

/* hw/rtl/sida_bind_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Queue binding table
// One queue number per device and stream, with a clear port used by the
// reset sweep, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sida_bind_table #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              clr_en,
  input  wire logic [ADDR_W-1:0] clr_addr,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem[clr_addr] <= sida_pkg::NO_QUEUE;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* hw/rtl/stream_id_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream ID allocator
// An accepted transaction passes through the first-stage registers and
// the result register; done rises together with its status, granted
// stream, free count and bindings.
// Throughput: one transaction per cycle while busy is low; the free
// stack is read at the accept edge and the binding tables from the
// first-stage registers. Reset: busy stays high while the stack and
// binding memories are swept one entry per cycle.
// ----------------------------------------------------------------------------
module stream_id_allocator #(
  parameter int NUM_STREAMS = 64,
  parameter int NUM_SQ      = 64,
  parameter int NUM_CQ      = 32,
  parameter int NUM_DEVICES = 1
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] device_number,
  input  wire logic [7:0] stream_number,
  input  wire logic [7:0] queue_number,
  output logic            done,
  output logic [2:0]      status,
  output logic [5:0]      granted_stream,
  output logic [6:0]      free_count,
  output logic [7:0]      bound_sq,
  output logic [7:0]      bound_cq
);

  localparam int DEPTH  = NUM_DEVICES * NUM_STREAMS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(NUM_STREAMS);
  localparam int CNT_W  = $clog2(NUM_STREAMS + 1);
  localparam int DSEL_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [DSEL_W-1:0] dsel,
                                                input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(dsel) * ADDR_W'(NUM_STREAMS);
    return base + ADDR_W'(idx);
  endfunction

  // Reset sweep.
  logic              clearing;
  logic [DSEL_W-1:0] clr_dev;
  logic [IDX_W-1:0]  clr_idx;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_dev  <= '0;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == IDX_W'(NUM_STREAMS - 1)) begin
        clr_idx <= '0;
        if (clr_dev == DSEL_W'(NUM_DEVICES - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_dev <= clr_dev + 1'b1;
        end
      end else begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  assign clr_addr = addr_of(clr_dev, clr_idx);
  assign busy     = clearing;

  // Accept-cycle decode.
  logic               accept;
  logic               dev_ok;
  logic               sid_ok;
  logic [DSEL_W-1:0]  dsel;
  logic [IDX_W-1:0]   sid_idx;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   n_dec;
  logic [CNT_W-1:0]   n_next;
  logic               cnt_we;
  logic               pop;
  logic               push;
  logic               sq_we;
  logic               cq_we;
  logic               have;
  sida_pkg::status_t  st;
  logic [CNT_W-1:0]   free_total [NUM_DEVICES];

  assign accept  = start && !busy;
  assign dev_ok  = device_number < 8'(NUM_DEVICES);
  assign sid_ok  = {1'b0, stream_number} < 9'(NUM_STREAMS);
  assign dsel    = device_number[DSEL_W-1:0];
  assign sid_idx = stream_number[IDX_W-1:0];
  assign n       = dev_ok ? free_total[dsel] : '0;
  assign n_dec   = n - 1'b1;

  always_comb begin
    st     = sida_pkg::ST_OK;
    n_next = n;
    pop    = 1'b0;
    push   = 1'b0;
    sq_we  = 1'b0;
    cq_we  = 1'b0;
    have   = 1'b0;
    if (!dev_ok) begin
      st = sida_pkg::ST_BAD_DEVICE;
    end else if (sida_pkg::op_t'(operation) == sida_pkg::OP_ALLOC) begin
      if (n == '0) begin
        st = sida_pkg::ST_NONE_FREE;
      end else begin
        pop    = 1'b1;
        have   = 1'b1;
        n_next = n_dec;
      end
    end else if (!sid_ok) begin
      st = sida_pkg::ST_BAD_STREAM;
    end else begin
      have = 1'b1;
      case (sida_pkg::op_t'(operation))
        sida_pkg::OP_FREE: begin
          if (n == CNT_W'(NUM_STREAMS)) begin
            st = sida_pkg::ST_LIST_FULL;
          end else begin
            push   = 1'b1;
            n_next = n + 1'b1;
          end
        end
        sida_pkg::OP_BIND_SQ: begin
          if (queue_number < 8'(NUM_SQ)) begin
            sq_we = 1'b1;
          end else begin
            st = sida_pkg::ST_BAD_QUEUE;
          end
        end
        sida_pkg::OP_BIND_CQ: begin
          if (queue_number < 8'(NUM_CQ)) begin
            cq_we = 1'b1;
          end else begin
            st = sida_pkg::ST_BAD_QUEUE;
          end
        end
        default: begin
          st = sida_pkg::ST_OK;
        end
      endcase
    end
  end

  assign cnt_we = accept && (pop || push);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < NUM_DEVICES; d++) begin
        free_total[d] <= CNT_W'(NUM_STREAMS);
      end
    end else if (cnt_we) begin
      free_total[dsel] <= n_next;
    end
  end

  // Free stack memory, read for a pop and written for a push at accept.
  logic [IDX_W-1:0]  stack_mem [DEPTH];
  logic [IDX_W-1:0]  stack_rdata;
  logic [ADDR_W-1:0] stack_raddr;
  logic [ADDR_W-1:0] stack_waddr;

  assign stack_raddr = addr_of(dsel, n_dec[IDX_W-1:0]);
  assign stack_waddr = addr_of(dsel, n[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (clearing) begin
      stack_mem[clr_addr] <= IDX_W'(NUM_STREAMS - 1) - clr_idx;
    end else if (accept && push) begin
      stack_mem[stack_waddr] <= sid_idx;
    end
    stack_rdata <= stack_mem[stack_raddr];
  end

  // First stage after accept.
  logic              s1_valid;
  logic [2:0]        s1_status;
  logic [CNT_W-1:0]  s1_count;
  logic              s1_have;
  logic              s1_pop;
  logic [DSEL_W-1:0] s1_dsel;
  logic [IDX_W-1:0]  s1_sid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_status <= st;
    s1_count  <= dev_ok ? n_next : '0;
    s1_have   <= have;
    s1_pop    <= pop;
    s1_dsel   <= dsel;
    s1_sid    <= sid_idx;
  end

  logic [IDX_W-1:0]  tgt_idx;
  logic [ADDR_W-1:0] bind_raddr;
  logic [ADDR_W-1:0] bind_waddr;
  logic [IDX_W+5:0]  granted_ext;
  logic [CNT_W+6:0]  count_ext;
  logic [7:0]        sq_rdata;
  logic [7:0]        cq_rdata;

  assign tgt_idx     = s1_pop ? stack_rdata : s1_sid;
  assign bind_raddr  = addr_of(s1_dsel, tgt_idx);
  assign bind_waddr  = addr_of(dsel, sid_idx);
  assign granted_ext = {6'd0, (s1_pop ? stack_rdata : IDX_W'(0))};
  assign count_ext   = {7'd0, s1_count};

  sida_bind_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_sq_table (
    .clk      (clk),
    .clr_en   (clearing),
    .clr_addr (clr_addr),
    .wr_en    (accept && sq_we),
    .wr_addr  (bind_waddr),
    .wr_data  (queue_number),
    .rd_addr  (bind_raddr),
    .rd_data  (sq_rdata)
  );

  sida_bind_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_cq_table (
    .clk      (clk),
    .clr_en   (clearing),
    .clr_addr (clr_addr),
    .wr_en    (accept && cq_we),
    .wr_addr  (bind_waddr),
    .wr_data  (queue_number),
    .rd_addr  (bind_raddr),
    .rd_data  (cq_rdata)
  );

  // Result register.
  logic s2_have;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    status         <= s1_status;
    granted_stream <= granted_ext[5:0];
    free_count     <= count_ext[6:0];
    s2_have        <= s1_have;
  end

  assign bound_sq = s2_have ? sq_rdata : sida_pkg::NO_QUEUE;
  assign bound_cq = s2_have ? cq_rdata : sida_pkg::NO_QUEUE;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("Accepted transaction produced no result.");

  a_no_work_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !cnt_we)
    else $error("Transaction in flight during the reset sweep.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    accept && dev_ok |-> n <= CNT_W'(NUM_STREAMS))
    else $error("Free count exceeds the stream count.");

  a_empty_alloc: assert property (@(posedge clk) disable iff (rst)
    done && status == sida_pkg::ST_NONE_FREE |->
      granted_stream == 6'd0 && bound_sq == sida_pkg::NO_QUEUE &&
      bound_cq == sida_pkg::NO_QUEUE)
    else $error("Failed allocate returned an identifier or bindings.");

endmodule
`default_nettype wire
